### rtl/core/multi_pattern_matcher_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multi-pattern matcher core
// ---------------------------------------------------------------------------
`ifndef MULTI_PATTERN_MATCHER_CORE_DEFINES_SVH
`define MULTI_PATTERN_MATCHER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define MPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define MPM_NEVER(label, cond, msg) \
  `MPM_ASSERT(label, !(cond), msg)

`endif

### rtl/core/mpm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mpm_pkg
// Shared constants, types and address helpers of the pattern matcher.
// ---------------------------------------------------------------------------
package mpm_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int ALPHABET   = 26;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = NODE_W + 1;
  localparam int SYM_W      = 5;
  localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;
  localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
  localparam int END_W      = 16;
  localparam int SUM_W      = END_W + NODE_W + 1;
  localparam int TOTAL_W    = 32;

  typedef enum logic [1:0] {
    K_LETTER = 2'd0,
    K_END    = 2'd1,
    K_BUILD  = 2'd2,
    K_TEXT   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef struct packed {
    logic [NODE_W-1:0] fail;
    logic [NODE_W-1:0] olink;
  } link_t;

  localparam int LINK_W = $bits(link_t);

  // Flat index of a goto entry: node row times alphabet plus letter
  function automatic logic [GOTO_AW-1:0] goto_addr(input logic [NODE_W-1:0] node,
                                                   input logic [SYM_W-1:0]  sym);
    goto_addr = GOTO_AW'(32'(node) * ALPHABET + 32'(sym));
  endfunction

endpackage

### rtl/core/mpm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mpm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module mpm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/core/multi_pattern_matcher_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_pattern_matcher_core
// Aho-Corasick matcher: trie load, breadth-first build, text scan.
// ---------------------------------------------------------------------------
// Usage:
//   An item (kind_i, symbol_i, start_of_text_i) is taken at a rising edge
//   with start high and busy low. Exactly one result follows: valid_o is
//   high for one cycle with status_o, matches_here_o and running_total_o.
//   The receiver cannot stall; each result shows for that single cycle.
//   busy drops in the cycle that shows the result, so a new item may be
//   started then.
//   Steps: a pattern letter runs S_DEC, S_P_EV; a pattern end S_DEC and,
//   unless answered there, S_E_EV; a rejected item S_DEC only; a text
//   letter S_DEC, S_T_EV, S_T_WLK, then S_T_ACC and S_T_WLK per node on
//   the output-link chain (reading its end count and links). Build: root
//   letters in S_B_R0/S_B_R1, then queued nodes letter by letter.
//   Reset: after rst_ni rises the goto table, end counts and links are
//   cleared by a sweep, one goto entry per cycle; busy stays high meanwhile.
// ---------------------------------------------------------------------------
`include "multi_pattern_matcher_core_defines.svh"
module multi_pattern_matcher_core import mpm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind_i,
  input  logic [SYM_W-1:0]    symbol_i,
  input  logic                start_of_text_i,
  output logic                valid_o,
  output logic [1:0]          status_o,
  output logic [END_W-1:0]    matches_here_o,
  output logic [TOTAL_W-1:0]  running_total_o
);

  typedef enum logic [16:0] {
    S_CLR   = 17'b00000000000000001,
    S_IDLE  = 17'b00000000000000010,
    S_DEC   = 17'b00000000000000100,
    S_P_EV  = 17'b00000000000001000,
    S_E_EV  = 17'b00000000000010000,
    S_T_EV  = 17'b00000000000100000,
    S_T_WLK = 17'b00000000001000000,
    S_T_ACC = 17'b00000000010000000,
    S_B_R0  = 17'b00000000100000000,
    S_B_R1  = 17'b00000001000000000,
    S_B_DEQ = 17'b00000010000000000,
    S_B_N0  = 17'b00000100000000000,
    S_B_N1  = 17'b00001000000000000,
    S_B_S0  = 17'b00010000000000000,
    S_B_S1  = 17'b00100000000000000,
    S_B_S2  = 17'b01000000000000000,
    S_B_S3  = 17'b10000000000000000
  } state_e;

  state_e               state_q, state_d;
  logic [GOTO_AW-1:0]   clr_q, clr_d;
  kind_e                kind_q, kind_d;
  logic [SYM_W-1:0]     sym_q, sym_d;
  logic                 sot_q, sot_d;
  logic [NODE_W-1:0]    cur_q, cur_d;
  logic                 drop_q, drop_d;
  logic                 built_q, built_d;
  logic [NODE_W-1:0]    scan_q, scan_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [CNT_W-1:0]     nodes_q, nodes_d;
  logic [CNT_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     tail_q, tail_d;
  logic [NODE_W-1:0]    n_q, n_d;
  logic [NODE_W-1:0]    f_q, f_d;
  logic [SYM_W-1:0]     s_q, s_d;
  logic [NODE_W-1:0]    c_q, c_d;
  logic [NODE_W-1:0]    cf_q, cf_d;
  logic [NODE_W-1:0]    p_q, p_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic                 valid_q, valid_d;
  status_e              status_q, status_d;
  logic [END_W-1:0]     here_q, here_d;

  logic                 g_we;
  logic [GOTO_AW-1:0]   g_waddr, g_raddr;
  logic [NODE_W-1:0]    g_wdata, g_rdata;
  logic                 e_we;
  logic [NODE_W-1:0]    e_waddr, e_raddr;
  logic [END_W-1:0]     e_wdata, e_rdata;
  logic                 l_we;
  logic [NODE_W-1:0]    l_waddr, l_raddr;
  link_t                l_wdata, l_rdata;
  logic                 q_we;
  logic [NODE_W-1:0]    q_waddr, q_raddr;
  logic [NODE_W-1:0]    q_wdata, q_rdata;

  logic                 sym_ok;
  logic [NODE_W-1:0]    text_node;
  logic [TOTAL_W:0]     total_sum;

  // Goto table, end counts, fail/output links, build queue
  mpm_ram #(.DEPTH(GOTO_DEPTH), .WIDTH(NODE_W)) u_goto (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .raddr_i(g_raddr), .rdata_o(g_rdata)
  );
  mpm_ram #(.DEPTH(MAX_NODES), .WIDTH(END_W)) u_end (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );
  mpm_ram #(.DEPTH(MAX_NODES), .WIDTH(LINK_W)) u_link (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(l_raddr), .rdata_o(l_rdata)
  );
  mpm_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  assign sym_ok    = (sym_q < SYM_W'(ALPHABET));
  assign text_node = sot_q ? '0 : scan_q;
  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(sum_q);

  // Sequence load, build and scan through the memories
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    kind_d   = kind_q;
    sym_d    = sym_q;
    sot_d    = sot_q;
    cur_d    = cur_q;
    drop_d   = drop_q;
    built_d  = built_q;
    scan_d   = scan_q;
    total_d  = total_q;
    nodes_d  = nodes_q;
    head_d   = head_q;
    tail_d   = tail_q;
    n_d      = n_q;
    f_d      = f_q;
    s_d      = s_q;
    c_d      = c_q;
    cf_d     = cf_q;
    p_d      = p_q;
    sum_d    = sum_q;
    valid_d  = 1'b0;
    status_d = status_q;
    here_d   = here_q;
    g_we     = 1'b0;
    g_waddr  = '0;
    g_wdata  = '0;
    g_raddr  = '0;
    e_we     = 1'b0;
    e_waddr  = '0;
    e_wdata  = '0;
    e_raddr  = '0;
    l_we     = 1'b0;
    l_waddr  = '0;
    l_wdata  = '0;
    l_raddr  = '0;
    q_we     = 1'b0;
    q_waddr  = '0;
    q_wdata  = '0;
    q_raddr  = '0;

    unique case (state_q)
      // Clear the stores after reset
      S_CLR: begin
        g_we    = 1'b1;
        g_waddr = clr_q;
        if (32'(clr_q) < MAX_NODES) begin
          e_we    = 1'b1;
          e_waddr = clr_q[NODE_W-1:0];
          l_we    = 1'b1;
          l_waddr = clr_q[NODE_W-1:0];
        end
        if (32'(clr_q) == GOTO_DEPTH - 1) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      // Take an item
      S_IDLE: begin
        if (start) begin
          kind_d  = kind_e'(kind_i);
          sym_d   = symbol_i;
          sot_d   = start_of_text_i;
          state_d = S_DEC;
        end
      end

      // Check the phase and, where needed, issue the first read
      S_DEC: begin
        unique case (kind_q)
          K_LETTER: begin
            if (built_q || !sym_ok) begin
              valid_d = 1'b1; status_d = ST_BAD; here_d = '0; state_d = S_IDLE;
            end else if (drop_q) begin
              valid_d = 1'b1; status_d = ST_FULL; here_d = '0; state_d = S_IDLE;
            end else begin
              g_raddr = goto_addr(cur_q, sym_q);
              state_d = S_P_EV;
            end
          end
          K_END: begin
            if (built_q) begin
              valid_d = 1'b1; status_d = ST_BAD; here_d = '0; state_d = S_IDLE;
            end else if (drop_q) begin
              cur_d = '0; drop_d = 1'b0;
              valid_d = 1'b1; status_d = ST_FULL; here_d = '0; state_d = S_IDLE;
            end else if (cur_q == '0) begin
              valid_d = 1'b1; status_d = ST_OK; here_d = '0; state_d = S_IDLE;
            end else begin
              e_raddr = cur_q;
              state_d = S_E_EV;
            end
          end
          K_BUILD: begin
            if (built_q) begin
              valid_d = 1'b1; status_d = ST_BAD; here_d = '0; state_d = S_IDLE;
            end else begin
              head_d  = '0;
              tail_d  = '0;
              s_d     = '0;
              state_d = S_B_R0;
            end
          end
          K_TEXT: begin
            if (!built_q || !sym_ok) begin
              valid_d = 1'b1; status_d = ST_BAD; here_d = '0; state_d = S_IDLE;
            end else begin
              if (sot_q) begin
                total_d = '0;
              end
              g_raddr = goto_addr(text_node, sym_q);
              state_d = S_T_EV;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      // Follow or create the child, or mark the pattern dropped when the store is full
      S_P_EV: begin
        valid_d = 1'b1;
        here_d  = '0;
        state_d = S_IDLE;
        if (g_rdata != '0) begin
          cur_d    = g_rdata;
          status_d = ST_OK;
        end else if (32'(nodes_q) >= MAX_NODES) begin
          drop_d   = 1'b1;
          status_d = ST_FULL;
        end else begin
          g_we     = 1'b1;
          g_waddr  = goto_addr(cur_q, sym_q);
          g_wdata  = nodes_q[NODE_W-1:0];
          cur_d    = nodes_q[NODE_W-1:0];
          nodes_d  = nodes_q + 1'b1;
          status_d = ST_OK;
        end
      end

      // Count the pattern end, saturating
      S_E_EV: begin
        if (e_rdata != '1) begin
          e_we    = 1'b1;
          e_waddr = cur_q;
          e_wdata = e_rdata + 1'b1;
        end
        cur_d = '0;
        valid_d = 1'b1; status_d = ST_OK; here_d = '0; state_d = S_IDLE;
      end

      // Advance the scan node
      S_T_EV: begin
        scan_d  = g_rdata;
        p_d     = g_rdata;
        sum_d   = '0;
        state_d = S_T_WLK;
      end

      // Walk the output-link chain
      S_T_WLK: begin
        if (p_q == '0) begin
          total_d  = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
          here_d   = (|sum_q[SUM_W-1:END_W]) ? '1 : sum_q[END_W-1:0];
          valid_d  = 1'b1;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end else begin
          e_raddr = p_q;
          l_raddr = p_q;
          state_d = S_T_ACC;
        end
      end

      S_T_ACC: begin
        sum_d   = sum_q + SUM_W'(e_rdata);
        p_d     = l_rdata.olink;
        state_d = S_T_WLK;
      end

      // Queue the children of the root
      S_B_R0: begin
        g_raddr = goto_addr('0, s_q);
        state_d = S_B_R1;
      end

      S_B_R1: begin
        if (g_rdata != '0 && 32'(tail_q) < MAX_NODES) begin
          q_we    = 1'b1;
          q_waddr = tail_q[NODE_W-1:0];
          q_wdata = g_rdata;
          tail_d  = tail_q + 1'b1;
        end
        if (32'(s_q) == ALPHABET - 1) begin
          state_d = S_B_DEQ;
        end else begin
          s_d     = s_q + 1'b1;
          state_d = S_B_R0;
        end
      end

      // Pop the next node or finish the build
      S_B_DEQ: begin
        if (head_q == tail_q) begin
          built_d = 1'b1;
          cur_d   = '0;
          drop_d  = 1'b0;
          scan_d  = '0;
          total_d = '0;
          valid_d = 1'b1; status_d = ST_OK; here_d = '0; state_d = S_IDLE;
        end else begin
          q_raddr = head_q[NODE_W-1:0];
          state_d = S_B_N0;
        end
      end

      S_B_N0: begin
        n_d     = q_rdata;
        head_d  = head_q + 1'b1;
        l_raddr = q_rdata;
        state_d = S_B_N1;
      end

      S_B_N1: begin
        f_d     = l_rdata.fail;
        s_d     = '0;
        state_d = S_B_S0;
      end

      // Per letter: read own edge, then the fail node's edge
      S_B_S0: begin
        g_raddr = goto_addr(n_q, s_q);
        state_d = S_B_S1;
      end

      S_B_S1: begin
        c_d     = g_rdata;
        g_raddr = goto_addr(f_q, s_q);
        state_d = S_B_S2;
      end

      S_B_S2: begin
        if (c_q != '0) begin
          cf_d    = g_rdata;
          e_raddr = g_rdata;
          l_raddr = g_rdata;
          state_d = S_B_S3;
        end else begin
          g_we    = 1'b1;
          g_waddr = goto_addr(n_q, s_q);
          g_wdata = g_rdata;
          if (32'(s_q) == ALPHABET - 1) begin
            state_d = S_B_DEQ;
          end else begin
            s_d     = s_q + 1'b1;
            state_d = S_B_S0;
          end
        end
      end

      // Set the child's links and queue it
      S_B_S3: begin
        l_we          = 1'b1;
        l_waddr       = c_q;
        l_wdata.fail  = cf_q;
        l_wdata.olink = (e_rdata != '0) ? cf_q : l_rdata.olink;
        if (32'(tail_q) < MAX_NODES) begin
          q_we    = 1'b1;
          q_waddr = tail_q[NODE_W-1:0];
          q_wdata = c_q;
          tail_d  = tail_q + 1'b1;
        end
        if (32'(s_q) == ALPHABET - 1) begin
          state_d = S_B_DEQ;
        end else begin
          s_d     = s_q + 1'b1;
          state_d = S_B_S0;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      kind_q   <= K_LETTER;
      sym_q    <= '0;
      sot_q    <= 1'b0;
      cur_q    <= '0;
      drop_q   <= 1'b0;
      built_q  <= 1'b0;
      scan_q   <= '0;
      total_q  <= '0;
      nodes_q  <= CNT_W'(1);
      head_q   <= '0;
      tail_q   <= '0;
      n_q      <= '0;
      f_q      <= '0;
      s_q      <= '0;
      c_q      <= '0;
      cf_q     <= '0;
      p_q      <= '0;
      sum_q    <= '0;
      valid_q  <= 1'b0;
      status_q <= ST_OK;
      here_q   <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      kind_q   <= kind_d;
      sym_q    <= sym_d;
      sot_q    <= sot_d;
      cur_q    <= cur_d;
      drop_q   <= drop_d;
      built_q  <= built_d;
      scan_q   <= scan_d;
      total_q  <= total_d;
      nodes_q  <= nodes_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      n_q      <= n_d;
      f_q      <= f_d;
      s_q      <= s_d;
      c_q      <= c_d;
      cf_q     <= cf_d;
      p_q      <= p_d;
      sum_q    <= sum_d;
      valid_q  <= valid_d;
      status_q <= status_d;
      here_q   <= here_d;
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign valid_o         = valid_q;
  assign status_o        = status_q;
  assign matches_here_o  = here_q;
  assign running_total_o = total_q;

  // Checks
  `MPM_ASSERT(a_result_after_work, valid_o |-> $past(busy), "result without an item")
  `MPM_ASSERT(a_accept_goes_busy, (start && !busy) |=> busy, "item not taken")
  `MPM_NEVER(a_nodes_bound, 32'(nodes_q) > MAX_NODES, "node count beyond store")
  `MPM_NEVER(a_match_needs_ok, valid_o && matches_here_o != '0 && status_o != ST_OK,
             "matches reported with error status")

endmodule
